/* design/i2a_pkg.sv */
// Shared types, constants and helpers for the integer-to-ASCII converter.
// No dependencies; every other design file refers to this package by scoped names.
package i2a_pkg;

  // Width of the value field on the input channel.
  localparam int unsigned VALUE_FIELD_W = 64;
  // Number of low value bits that take part in a conversion (8 to 64).
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned OPCODE_W = 2;

  // Twenty decimal digits cover any 64-bit magnitude; hex needs at most sixteen.
  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned DIGIT_BITS = 4 * MAX_DIGITS;
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned STEP_CNT_W = $clog2(VALUE_WIDTH);

  localparam int unsigned COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Format codes.
  localparam logic [OPCODE_W-1:0] OP_DEC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_HEX_UP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HEX_LO = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_PTR = 2'd3;

  // Fixed characters.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X = 8'h78;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_LO_A = 8'h61;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;      // capture an accepted input word
    logic      step;      // one double-dabble shift
    logic      set_idx;   // point at the most significant nonzero digit
    logic      dec_idx;   // move to the next lower digit
    logic      emit;      // load the output register
    char_sel_e sel;
    logic      last;
  } i2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic is_dec;
    logic is_ptr;
    logic neg;
    logic idx_zero;
  } i2a_sts_t;

  // Maps a digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CHAR_UP_A : CHAR_LO_A;
      if (d < 4'd10) begin
        digit_char = CHAR_ZERO + {4'b0000, d};
      end else begin
        digit_char = base + {4'b0000, d} - 8'd10;
      end
    end
  endfunction

endpackage

/* design/i2a_in_if.sv */
// Input channel of the converter: valid/ready handshake with value and format code.
// Depends on i2a_pkg for the field widths.
interface i2a_in_if;
  logic                               valid;
  logic                               ready;
  logic [i2a_pkg::VALUE_FIELD_W-1:0]  value;
  logic [i2a_pkg::OPCODE_W-1:0]       opcode;

  modport source (output valid, output value, output opcode, input ready);
  modport sink (input valid, input value, input opcode, output ready);
endinterface

/* design/i2a_out_if.sv */
// Output channel of the converter: one ASCII character per word with last marker and count.
// Depends on i2a_pkg for the count width.
interface i2a_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    ascii_char;
  logic                          last_char;
  logic [i2a_pkg::COUNT_W-1:0]   chars_so_far;

  modport source (output valid, output ascii_char, output last_char, output chars_so_far,
                  input ready);
  modport sink (input valid, input ascii_char, input last_char, input chars_so_far,
                output ready);
endinterface

/* design/i2a_datapath.sv */
// Datapath: operand capture, double-dabble digit register, digit pointer and output register.
// Depends on i2a_pkg; driven by commands from i2a_controller.
module i2a_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [i2a_pkg::VALUE_FIELD_W-1:0] value_i,
  input  logic [i2a_pkg::OPCODE_W-1:0]      opcode_i,
  input  i2a_pkg::i2a_cmd_t                 cmd_i,
  output i2a_pkg::i2a_sts_t                 sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [7:0]                        ascii_char_o,
  output logic                              last_char_o,
  output logic [i2a_pkg::COUNT_W-1:0]       chars_so_far_o
);

  logic [i2a_pkg::VALUE_WIDTH-1:0] val_in;
  logic [i2a_pkg::VALUE_WIDTH-1:0] mag_in;
  logic                            is_dec_in;
  logic                            neg_in;

  logic [i2a_pkg::VALUE_WIDTH-1:0] shift_q;
  logic [i2a_pkg::DIGIT_BITS-1:0]  digits_q;
  logic [i2a_pkg::DIGIT_BITS-1:0]  adj;
  logic [i2a_pkg::IDX_W-1:0]       idx_q;
  logic [i2a_pkg::IDX_W-1:0]       top_idx;
  logic                            is_dec_q;
  logic                            is_ptr_q;
  logic                            neg_q;
  logic                            upper_q;

  logic                            out_valid_q;
  logic [7:0]                      ascii_q;
  logic [7:0]                      ascii_d;
  logic                            last_q;
  logic [i2a_pkg::COUNT_W-1:0]     total_q;
  logic [i2a_pkg::COUNT_W-1:0]     total_d;
  logic [3:0]                      cur_digit;

  assign val_in    = value_i[i2a_pkg::VALUE_WIDTH-1:0];
  assign is_dec_in = (opcode_i == i2a_pkg::OP_DEC);
  assign neg_in    = is_dec_in & val_in[i2a_pkg::VALUE_WIDTH-1];
  // The magnitude of the most negative value is still exact as an unsigned number.
  assign mag_in    = neg_in ? (~val_in + 1'b1) : val_in;

  // Add-3 correction on every BCD digit before each shift.
  always_comb begin
    for (int i = 0; i < i2a_pkg::MAX_DIGITS; i++) begin
      if (digits_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits_q[4*i +: 4];
      end
    end
  end

  // Highest nonzero digit; zero prints as a single digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < i2a_pkg::MAX_DIGITS; i++) begin
      if (digits_q[4*i +: 4] != 4'd0) begin
        top_idx = i2a_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      shift_q  <= mag_in;
      is_dec_q <= is_dec_in;
      is_ptr_q <= (opcode_i == i2a_pkg::OP_PTR);
      neg_q    <= neg_in;
      upper_q  <= (opcode_i == i2a_pkg::OP_HEX_UP) || is_dec_in;
      if (is_dec_in) begin
        digits_q <= '0;
      end else begin
        digits_q <= i2a_pkg::DIGIT_BITS'(val_in);
      end
    end else if (cmd_i.step) begin
      digits_q <= {adj[i2a_pkg::DIGIT_BITS-2:0], shift_q[i2a_pkg::VALUE_WIDTH-1]};
      shift_q  <= {shift_q[i2a_pkg::VALUE_WIDTH-2:0], 1'b0};
    end
    if (cmd_i.set_idx) begin
      idx_q <= top_idx;
    end else if (cmd_i.dec_idx) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  assign cur_digit = digits_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    case (cmd_i.sel)
      i2a_pkg::SEL_MINUS: ascii_d = i2a_pkg::CHAR_MINUS;
      i2a_pkg::SEL_ZERO:  ascii_d = i2a_pkg::CHAR_ZERO;
      i2a_pkg::SEL_X:     ascii_d = i2a_pkg::CHAR_X;
      i2a_pkg::SEL_DIGIT: ascii_d = i2a_pkg::digit_char(cur_digit, upper_q);
      default:            ascii_d = i2a_pkg::CHAR_ZERO;
    endcase
  end

  assign total_d = (total_q == i2a_pkg::COUNT_MAX) ? total_q : total_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
      total_q     <= total_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ascii_q <= ascii_d;
      last_q  <= cmd_i.last;
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.is_dec    = is_dec_q;
  assign sts_o.is_ptr    = is_ptr_q;
  assign sts_o.neg       = neg_q;
  assign sts_o.idx_zero  = (idx_q == '0);

  assign out_valid_o    = out_valid_q;
  assign ascii_char_o   = ascii_q;
  assign last_char_o    = last_q;
  assign chars_so_far_o = total_q;

endmodule

/* design/i2a_controller.sv */
// Controller: sequences operand load, digit extraction, prefix characters and digit output.
// Depends on i2a_pkg; drives i2a_datapath through command and status structs.
module i2a_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2a_pkg::i2a_sts_t sts_i,
  output i2a_pkg::i2a_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_PFX0 = 3'd4;
  localparam logic [2:0] ST_PFX1 = 3'd5;
  localparam logic [2:0] ST_DIG  = 3'd6;

  logic [2:0]                       state_q;
  logic [2:0]                       state_d;
  logic [i2a_pkg::STEP_CNT_W-1:0]   cnt_q;
  logic [i2a_pkg::STEP_CNT_W-1:0]   cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.set_idx = 1'b0;
    cmd_o.dec_idx = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.sel     = i2a_pkg::SEL_DIGIT;
    cmd_o.last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = i2a_pkg::STEP_CNT_W'(i2a_pkg::VALUE_WIDTH - 1);
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        // Hex digits are already in place; decimal runs one shift per cycle.
        if (!sts_i.is_dec) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.set_idx = 1'b1;
        if (sts_i.neg) begin
          state_d = ST_SIGN;
        end else if (sts_i.is_ptr) begin
          state_d = ST_PFX0;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = i2a_pkg::SEL_MINUS;
          state_d    = ST_DIG;
        end
      end
      ST_PFX0: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = i2a_pkg::SEL_ZERO;
          state_d    = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = i2a_pkg::SEL_X;
          state_d    = ST_DIG;
        end
      end
      ST_DIG: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = i2a_pkg::SEL_DIGIT;
          cmd_o.last = sts_i.idx_zero;
          if (sts_i.idx_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dec_idx = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/integer_to_ascii_converter_top.sv */
// Top level of the integer-to-ASCII converter: joins controller and datapath to the channels.
// Depends on i2a_pkg, i2a_in_if, i2a_out_if, i2a_controller and i2a_datapath.
//
// The input channel takes one word holding a 64-bit value and a format code:
// signed decimal, uppercase hex, lowercase hex, or pointer ("0x" then lowercase
// hex). The output channel returns the characters most significant first, one
// per word, with last_char set on the final one and a saturating running count
// of every character sent since reset.
// One conversion is in flight at a time. After a word is accepted, decimal
// digits are extracted by a double-dabble shift register, one bit per cycle;
// hex needs no extraction. Characters then leave at one per cycle while the
// receiver is ready. A conversion gives at most 20 characters, and the
// double-dabble loop sets the decimal rate.
// The output register decouples the sides: a new word is accepted while the
// last character of the previous conversion still waits to be taken. When the
// receiver stalls, the current character holds and the sequencer waits.
// Reset clears the sequencer, the output valid flag and the character count.
module integer_to_ascii_converter_top (
  input logic       clk_i,
  input logic       rst_ni,
  i2a_in_if.sink    in_i,
  i2a_out_if.source out_o
);

  i2a_pkg::i2a_cmd_t cmd;
  i2a_pkg::i2a_sts_t sts;

  i2a_controller u_i2a_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2a_datapath u_i2a_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (in_i.value),
    .opcode_i       (in_i.opcode),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .ascii_char_o   (out_o.ascii_char),
    .last_char_o    (out_o.last_char),
    .chars_so_far_o (out_o.chars_so_far)
  );

endmodule

/* design/i2a_checker.sv */
// Port-level checker for the integer-to-ASCII converter, bound to the top level.
// Depends on i2a_pkg for field widths.
module i2a_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [7:0]                  ascii_char_i,
  input logic                        last_char_i,
  input logic [i2a_pkg::COUNT_W-1:0] chars_so_far_i
);

  // A stalled word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A stalled word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(ascii_char_i) && $stable(last_char_i)
      && $stable(chars_so_far_i))
    else $error("output payload changed while stalled");

  // Only one conversion is in flight: the block is busy right after taking a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  // A new word directly after a transfer carries the next count, or the saturated one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i
      || chars_so_far_i == $past(chars_so_far_i) + 1'b1
      || chars_so_far_i == i2a_pkg::COUNT_MAX)
    else $error("character count did not advance");

endmodule

bind integer_to_ascii_converter_top i2a_checker u_i2a_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .ascii_char_i   (out_o.ascii_char),
  .last_char_i    (out_o.last_char),
  .chars_so_far_i (out_o.chars_so_far)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for integer_to_ascii_converter_top: a directed table, then random words.
// Depends on i2a_pkg, i2a_in_if, i2a_out_if and the converter RTL below them.
module tb;

  // A quiet spell this long on both channels means the converter has hung.
  // The slowest correct gap is a decimal conversion plus a long random stall,
  // so this is many times over.
  localparam int unsigned STALL_LIMIT = 4000;
  // Cycles allowed after the last expected word, to catch stray characters.
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned RESET_CYCLES = 12;

  // The random part runs in four phases with different idling on each side:
  // none, sender idle, receiver stalling, then both lightly.
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned WORDS_PER_PHASE = 90;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 73, 0, 11};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 73, 11};

  localparam string UPPER_DIGITS = "0123456789ABCDEF";
  localparam string LOWER_DIGITS = "0123456789abcdef";

  typedef byte unsigned char_list_t[$];

  // One character word as it should appear on the output channel.
  typedef struct {
    logic [7:0]                  ch;
    logic                        last;
    logic [i2a_pkg::COUNT_W-1:0] total;
  } char_word_t;

  // Directed stimulus. Where the text is filled in, it is the exact string the
  // converter must produce; an empty text means the row is checked against the
  // formatter below.
  typedef struct {
    logic [i2a_pkg::VALUE_FIELD_W-1:0] value;
    logic [i2a_pkg::OPCODE_W-1:0]      opcode;
    string                             text;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 22;
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{64'd0, i2a_pkg::OP_DEC, "0"},
    '{64'd0, i2a_pkg::OP_HEX_UP, "0"},
    '{64'd0, i2a_pkg::OP_HEX_LO, "0"},
    '{64'd0, i2a_pkg::OP_PTR, "0x0"},
    '{64'd1, i2a_pkg::OP_DEC, "1"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_DEC, "-1"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_DEC, "-9223372036854775808"},
    '{64'h7FFF_FFFF_FFFF_FFFF, i2a_pkg::OP_DEC, "9223372036854775807"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_HEX_UP, "FFFFFFFFFFFFFFFF"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_HEX_LO, "ffffffffffffffff"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_PTR, "0xffffffffffffffff"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_PTR, "0x8000000000000000"},
    '{64'h0123_4567_89AB_CDEF, i2a_pkg::OP_HEX_UP, "123456789ABCDEF"},
    '{64'h0123_4567_89AB_CDEF, i2a_pkg::OP_HEX_LO, "123456789abcdef"},
    '{64'h0000_0000_0000_000F, i2a_pkg::OP_HEX_UP, "F"},
    '{64'd9, i2a_pkg::OP_DEC, ""},
    '{64'd10, i2a_pkg::OP_DEC, ""},
    '{64'd1000000000000000000, i2a_pkg::OP_DEC, ""},
    '{64'hFFFF_FFFF_FFFF_FFF6, i2a_pkg::OP_DEC, ""},
    '{64'h8000_0000_0000_0001, i2a_pkg::OP_DEC, ""},
    '{64'h0000_0000_DEAD_BEEF, i2a_pkg::OP_PTR, ""},
    '{64'hA5A5_5A5A_C3C3_3C3C, i2a_pkg::OP_HEX_LO, ""}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  // Channel drivers; every converter input is known from time zero.
  logic                              send_valid = 1'b0;
  logic [i2a_pkg::VALUE_FIELD_W-1:0] send_value = '0;
  logic [i2a_pkg::OPCODE_W-1:0]      send_opcode = i2a_pkg::OP_DEC;
  logic                              recv_ready = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Characters still owed by the converter, oldest first, and the running
  // character count they were predicted with.
  char_word_t                  owed_chars[$];
  logic [i2a_pkg::COUNT_W-1:0] char_count = '0;

  int mismatch_count = 0;
  int quiet_cycles = 0;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  assign in_ch.valid  = send_valid;
  assign in_ch.value  = send_value;
  assign in_ch.opcode = send_opcode;
  assign out_ch.ready = recv_ready;

  integer_to_ascii_converter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Formats a value the way the converter should: only the low VALUE_WIDTH
  // bits count, signed decimal negates a set sign bit (the most negative value
  // comes out right because the magnitude is kept unsigned), and hex digits are
  // peeled off four bits at a time.
  function automatic char_list_t format_value(input logic [i2a_pkg::VALUE_FIELD_W-1:0] raw,
                                              input logic [i2a_pkg::OPCODE_W-1:0] op);
    char_list_t  chars;
    logic [63:0] mag;
    logic [63:0] base;
    logic        negative;
    string       digit_set;
    mag = (raw << (64 - i2a_pkg::VALUE_WIDTH)) >> (64 - i2a_pkg::VALUE_WIDTH);
    negative = (op == i2a_pkg::OP_DEC) && mag[i2a_pkg::VALUE_WIDTH-1];
    if (negative) begin
      mag = ~mag + 64'd1;
      mag = (mag << (64 - i2a_pkg::VALUE_WIDTH)) >> (64 - i2a_pkg::VALUE_WIDTH);
    end
    digit_set = (op == i2a_pkg::OP_DEC || op == i2a_pkg::OP_HEX_UP) ? UPPER_DIGITS
                                                                     : LOWER_DIGITS;
    base = (op == i2a_pkg::OP_DEC) ? 64'd10 : 64'd16;
    do begin
      chars.push_front(digit_set[int'(mag % base)]);
      mag = mag / base;
    end while (mag != 0);
    if (negative) begin
      chars.push_front(i2a_pkg::CHAR_MINUS);
    end else if (op == i2a_pkg::OP_PTR) begin
      chars.push_front(i2a_pkg::CHAR_X);
      chars.push_front(i2a_pkg::CHAR_ZERO);
    end
    return chars;
  endfunction

  task automatic report_mismatch(input string detail);
    $display("[%0t] mismatch: %s", $realtime, detail);
    mismatch_count++;
  endtask

  // Offers one word to the converter, holding it until it is taken, and then
  // books its characters. Starts and ends at a falling edge.
  task automatic send_word(input logic [i2a_pkg::VALUE_FIELD_W-1:0] value,
                           input logic [i2a_pkg::OPCODE_W-1:0] op,
                           input char_list_t chars);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      send_valid <= 1'b0;
      @(negedge clk_i);
    end
    send_valid  <= 1'b1;
    send_value  <= value;
    send_opcode <= op;
    do @(posedge clk_i); while (!in_ch.ready);
    // The running count saturates rather than wrapping.
    foreach (chars[i]) begin
      if (char_count != i2a_pkg::COUNT_MAX) char_count = char_count + 1'b1;
      owed_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1), total: char_count});
    end
    @(negedge clk_i);
  endtask

  // Receiver: ready is redrawn every falling edge from the phase's stall rate.
  always @(negedge clk_i) begin
    recv_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Output checker: every character word taken is compared with the oldest
  // owed one, field by field.
  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (owed_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_ch.ascii_char));
      end else begin
        want = owed_chars.pop_front();
        if (out_ch.ascii_char !== want.ch)
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    out_ch.ascii_char, want.ch));
        if (out_ch.last_char !== want.last)
          report_mismatch($sformatf("last marker %b, wanted %b", out_ch.last_char, want.last));
        if (out_ch.chars_so_far !== want.total)
          report_mismatch($sformatf("count %0d, wanted %0d", out_ch.chars_so_far, want.total));
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[%0t] watchdog: no traffic for %0d cycles, %0d characters owed",
                   $realtime, quiet_cycles, owed_chars.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    char_list_t                        chars;
    logic [i2a_pkg::VALUE_FIELD_W-1:0] raw;
    logic [i2a_pkg::OPCODE_W-1:0]      op;
    // Reset is held for a fixed number of cycles, once, then released
    // away from the rising edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, with no idling on either side.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].text.len() != 0) begin
        chars = {};
        for (int c = 0; c < directed_rows[i].text.len(); c++)
          chars.push_back(directed_rows[i].text[c]);
      end else begin
        chars = format_value(directed_rows[i].value, directed_rows[i].opcode);
      end
      send_word(directed_rows[i].value, directed_rows[i].opcode, chars);
    end

    // Random words. Full 64-bit values exercise every bit; shifted-down and
    // inverted ones give short positive and short negative numbers, so the
    // string lengths vary, and zero turns up now and then.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: raw = '0;
          1, 2: raw = raw >> $urandom_range(1, 63);
          3, 4: raw = ~(raw >> $urandom_range(1, 63));
          default: ;
        endcase
        op = i2a_pkg::OPCODE_W'($urandom_range(0, 3));
        send_word(raw, op, format_value(raw, op));
      end
    end
    send_valid <= 1'b0;

    // Let every owed character arrive, then watch a little longer for extras.
    while (owed_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
